// File: sv/afs_pkg.sv
// ---------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the allpass shelving and peak equalizer.
// ---------------------------------------------------------------------------
package afs_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int ACC_W          = 64;
  localparam int GAIN_FRAC_BITS = 24;
  // width of the gain product after the fraction bits are dropped
  localparam int GAIN_INT_W     = ACC_W - GAIN_FRAC_BITS;

  // filter type codes
  localparam logic [2:0] FT_LOW_SHELF  = 3'd0;
  localparam logic [2:0] FT_HIGH_SHELF = 3'd1;
  localparam logic [2:0] FT_PEAK       = 3'd2;
  localparam logic [2:0] FT_FIRST_SEC  = 3'd3;
  localparam logic [2:0] FT_SECOND_SEC = 3'd4;

  typedef enum logic [2:0] {
    MAC_NOP  = 3'd0,
    MAC_CLR  = 3'd1,  // acc = 2*p
    MAC_ADD  = 3'd2,  // acc += 2*p
    MAC_SUB  = 3'd3,  // acc -= 2*p
    MAC_LOAD = 3'd4   // acc = p
  } mac_op_t;

  typedef struct packed {
    mac_op_t                     op;
    logic signed [SAMPLE_W-1:0]  opa;
    logic signed [SAMPLE_W-1:0]  opb;
  } mac_req_t;

  typedef struct packed {
    logic        [2:0]           filter_type;
    logic signed [SAMPLE_W-1:0]  coef_a0;
    logic signed [SAMPLE_W-1:0]  coef_a1;
    logic signed [SAMPLE_W-1:0]  coef_a2;
    logic signed [SAMPLE_W-1:0]  coef_b1_first;
    logic signed [SAMPLE_W-1:0]  coef_b1_half;
    logic signed [SAMPLE_W-1:0]  coef_b2;
    logic signed [SAMPLE_W-1:0]  shelf_gain;
  } cfg_t;

endpackage

// File: sv/afs_mac.sv
// ---------------------------------------------------------------------------
// afs_mac
// Shared 32x32 signed multiplier with a registered product and a 64-bit
// wrapping accumulator behind it.
// ---------------------------------------------------------------------------
module afs_mac import afs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_req_t                req,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_r;
  mac_op_t                 op_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic        [ACC_W-1:0] dbl;

  assign prod = req.opa * req.opb;
  assign dbl  = {prod_r[ACC_W-2:0], 1'b0};

  always_comb begin
    acc_nxt = acc_r;
    case (op_r)
      MAC_CLR:  acc_nxt = dbl;
      MAC_ADD:  acc_nxt = acc_r + dbl;
      MAC_SUB:  acc_nxt = acc_r - dbl;
      MAC_LOAD: acc_nxt = prod_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    acc_r  <= acc_nxt;
    if (!rst_n) begin
      op_r <= MAC_NOP;
    end else begin
      op_r <= req.op;
    end
  end

  assign acc = acc_r;

endmodule

// File: sv/afs_seq.sv
// ---------------------------------------------------------------------------
// afs_seq
// Sequencer: steps the shared multiplier through the IIR section taps,
// keeps the sample history, then, for the shelf and peak types, runs the
// shelf gain multiply and the final saturating sum.
// ---------------------------------------------------------------------------
module afs_seq import afs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       idle,
  output logic                       res_valid,
  output logic signed [SAMPLE_W-1:0] res_data,
  input  logic                       res_take
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MAC   = 9'b000000010,
    S_DRAIN = 9'b000000100,
    S_HALF  = 9'b000001000,
    S_GMUL  = 9'b000010000,
    S_GWAIT = 9'b000100000,
    S_ROUND = 9'b001000000,
    S_SAT   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam logic [2:0] LAST_FIRST  = 3'd2;
  localparam logic [2:0] LAST_SECOND = 3'd6;
  localparam logic signed [ACC_W-1:0] RND_BIAS =
    ACC_W'((ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1));
  localparam logic signed [SAMPLE_W-1:0] S32_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S32_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  state_t                     state_r, state_nxt;
  logic [2:0]                 step_r, step_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [SAMPLE_W-1:0] xh0_r, xh0_nxt, xh1_r, xh1_nxt;
  logic signed [SAMPLE_W-1:0] yh0_r, yh0_nxt, yh1_r, yh1_nxt;
  logic signed [SAMPLE_W-1:0] d_r, d_nxt, term_r, term_nxt;
  logic signed [GAIN_INT_W-1:0] g_r, g_nxt;
  logic signed [SAMPLE_W-1:0] res_r, res_nxt;

  logic                       order2;
  logic [2:0]                 last_step;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [SAMPLE_W-1:0] f;
  logic signed [SAMPLE_W:0]   sum33, diff33;
  logic signed [GAIN_INT_W:0] total;
  mac_req_t                   req;

  assign order2    = cfg.filter_type inside {FT_PEAK, FT_SECOND_SEC};
  assign last_step = order2 ? LAST_SECOND : LAST_FIRST;
  assign f         = acc[ACC_W-1:ACC_W-SAMPLE_W];
  assign sum33     = (SAMPLE_W+1)'(f) + (SAMPLE_W+1)'(x_r);
  assign diff33    = (SAMPLE_W+1)'(x_r) - (SAMPLE_W+1)'(f);
  // truncate the gain product toward zero
  assign acc_rnd   = acc + (acc[ACC_W-1] ? RND_BIAS : '0);
  assign total     = (GAIN_INT_W+1)'(g_r) + (GAIN_INT_W+1)'(term_r);

  afs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .acc   (acc)
  );

  // tap selection for the section
  always_comb begin
    req.op  = MAC_NOP;
    req.opa = cfg.coef_a0;
    req.opb = x_r;
    if (state_r == S_MAC) begin
      if (order2) begin
        case (step_r)
          3'd0:    begin req.op = MAC_CLR; req.opa = cfg.coef_a0;      req.opb = x_r;   end
          3'd1:    begin req.op = MAC_ADD; req.opa = cfg.coef_a1;      req.opb = xh0_r; end
          3'd2:    begin req.op = MAC_ADD; req.opa = cfg.coef_a1;      req.opb = xh0_r; end
          3'd3:    begin req.op = MAC_ADD; req.opa = cfg.coef_a2;      req.opb = xh1_r; end
          3'd4:    begin req.op = MAC_SUB; req.opa = cfg.coef_b1_half; req.opb = yh0_r; end
          3'd5:    begin req.op = MAC_SUB; req.opa = cfg.coef_b1_half; req.opb = yh0_r; end
          default: begin req.op = MAC_SUB; req.opa = cfg.coef_b2;      req.opb = yh1_r; end
        endcase
      end else begin
        case (step_r)
          3'd0:    begin req.op = MAC_CLR; req.opa = cfg.coef_a0;       req.opb = x_r;   end
          3'd1:    begin req.op = MAC_ADD; req.opa = cfg.coef_a1;       req.opb = xh0_r; end
          default: begin req.op = MAC_SUB; req.opa = cfg.coef_b1_first; req.opb = yh0_r; end
        endcase
      end
    end else if (state_r == S_GMUL) begin
      req.op  = MAC_LOAD;
      req.opa = d_r;
      req.opb = cfg.shelf_gain;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    xh0_nxt   = xh0_r;
    xh1_nxt   = xh1_r;
    yh0_nxt   = yh0_r;
    yh1_nxt   = yh1_r;
    d_nxt     = d_r;
    term_nxt  = term_r;
    g_nxt     = g_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          x_nxt    = sample;
          step_nxt = '0;
          if (cfg.filter_type inside {[FT_LOW_SHELF:FT_SECOND_SEC]}) begin
            state_nxt = S_MAC;
          end else begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_MAC: begin
        step_nxt = step_r + 3'd1;
        if (step_r == last_step) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_HALF;
      end
      S_HALF: begin
        xh0_nxt = x_r;
        yh0_nxt = f;
        if (order2) begin
          xh1_nxt = xh0_r;
          yh1_nxt = yh0_r;
        end
        if (cfg.filter_type == FT_HIGH_SHELF) begin
          d_nxt    = sum33[SAMPLE_W:1];
          term_nxt = diff33[SAMPLE_W:1];
        end else begin
          d_nxt    = diff33[SAMPLE_W:1];
          term_nxt = sum33[SAMPLE_W:1];
        end
        if (cfg.filter_type inside {FT_FIRST_SEC, FT_SECOND_SEC}) begin
          res_nxt   = f;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_GMUL;
        end
      end
      S_GMUL: begin
        state_nxt = S_GWAIT;
      end
      S_GWAIT: begin
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        g_nxt     = acc_rnd[ACC_W-1:GAIN_FRAC_BITS];
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (total[GAIN_INT_W:SAMPLE_W-1] != {(GAIN_INT_W-SAMPLE_W+2){total[GAIN_INT_W]}})
        begin
          res_nxt = total[GAIN_INT_W] ? S32_MIN : S32_MAX;
        end else begin
          res_nxt = total[SAMPLE_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    d_r    <= d_nxt;
    term_r <= term_nxt;
    g_r    <= g_nxt;
    res_r  <= res_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      xh0_r   <= '0;
      xh1_r   <= '0;
      yh0_r   <= '0;
      yh1_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      xh0_r   <= xh0_nxt;
      xh1_r   <= xh1_nxt;
      yh0_r   <= yh0_nxt;
      yh1_r   <= yh1_nxt;
    end
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

endmodule

// File: sv/allpass_shelving_filter.sv
// ---------------------------------------------------------------------------
// allpass_shelving_filter
// Allpass-based shelving and peak equalizer: one Q31 IIR section on a
// shared multiplier; shelf and peak add Q8.24 gain and 32-bit saturation.
// ---------------------------------------------------------------------------
//  channel | ports                         | transfer
//  --------+-------------------------------+----------------------------
//  input   | in_valid, in_ready, in_sample_in   | valid & ready
//  output  | out_valid, out_ready, out_sample_out | valid & ready
//  config  | cfg_we, cfg_index, cfg_wdata  | cfg_we, no wait
//
// After a sample is accepted the sequencer runs the section taps, drains
// the multiplier and forms the allpass halves; shelf and peak then add
// the gain multiply, rounding and saturation, and an undefined filter
// type gives a zero result. in_ready comes back as the result enters the
// output register. A result waiting on out_ready in the output register
// leaves the sequencer free; only a second finished result stalls it.
// Reset (rst_n, synchronous) resets history, state, config and out_valid.
// ---------------------------------------------------------------------------
module allpass_shelving_filter import afs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [SAMPLE_W-1:0]        cfg_wdata
);

  localparam logic [2:0] REG_FILTER_TYPE = 3'd0;
  localparam logic [2:0] REG_A0          = 3'd1;
  localparam logic [2:0] REG_A1          = 3'd2;
  localparam logic [2:0] REG_A2          = 3'd3;
  localparam logic [2:0] REG_B1_FIRST    = 3'd4;
  localparam logic [2:0] REG_B1_HALF     = 3'd5;
  localparam logic [2:0] REG_B2          = 3'd6;
  localparam logic [2:0] REG_GAIN        = 3'd7;
  localparam logic signed [SAMPLE_W-1:0] GAIN_ONE =
    SAMPLE_W'(SAMPLE_W'(1) << GAIN_FRAC_BITS);
  localparam cfg_t CFG_RESET = '{
    filter_type:   FT_LOW_SHELF,
    coef_a0:       '0,
    coef_a1:       '0,
    coef_a2:       '0,
    coef_b1_first: '0,
    coef_b1_half:  '0,
    coef_b2:       '0,
    shelf_gain:    GAIN_ONE
  };

  cfg_t                       cfg_r, cfg_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                       seq_idle;
  logic                       res_valid;
  logic signed [SAMPLE_W-1:0] res_data;
  logic                       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = seq_idle;

  afs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_valid && seq_idle),
    .sample    (in_sample_in),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (slot_free)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_TYPE: cfg_nxt.filter_type   = cfg_wdata[2:0];
        REG_A0:          cfg_nxt.coef_a0       = cfg_wdata;
        REG_A1:          cfg_nxt.coef_a1       = cfg_wdata;
        REG_A2:          cfg_nxt.coef_a2       = cfg_wdata;
        REG_B1_FIRST:    cfg_nxt.coef_b1_first = cfg_wdata;
        REG_B1_HALF:     cfg_nxt.coef_b1_half  = cfg_wdata;
        REG_B2:          cfg_nxt.coef_b2       = cfg_wdata;
        REG_GAIN:        cfg_nxt.shelf_gain    = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // output register, loaded when the previous result has gone out
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (slot_free) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule
